// ----- src/stuz_pkg.sv -----
// Types, codes and permute functions shared by the vector permute unit.
package stuz_pkg;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_TRN   = 3'd2,
        OP_UZP   = 3'd3,
        OP_ZIP   = 3'd4
    } opcode_t;

    localparam logic [1:0] SIZE_8    = 2'd0;
    localparam logic [1:0] SIZE_16   = 2'd1;
    localparam logic [1:0] SIZE_32   = 2'd2;
    localparam logic [1:0] SIZE_RSVD = 2'd3;

    // Element sizes in bytes.
    localparam int EB_8  = 8 / 8;
    localparam int EB_16 = 16 / 8;
    localparam int EB_32 = 32 / 8;

    // Width of an operand index widened so that index plus one and the
    // largest register count both fit.
    localparam int IDX_EXT_W = 7;

    // Transpose of one register pair; returns {new_m, new_d}.
    function automatic logic [127:0] trn_core(input logic [63:0] a, input logic [63:0] b,
                                              input logic same, input int eb);
        logic [63:0] na;
        logic [63:0] nb;
        na = a;
        nb = b;
        for (int e = 0; e < 4; e++) begin
            for (int k = 0; k < 4; k++) begin
                if (((2 * e + 1) * eb < 8) && (k < eb)) begin
                    if (same) begin
                        na[((2 * e + 1) * eb + k) * 8 +: 8] = a[(2 * e * eb + k) * 8 +: 8];
                        na[(2 * e * eb + k) * 8 +: 8] = a[((2 * e + 1) * eb + k) * 8 +: 8];
                    end
                    else begin
                        na[((2 * e + 1) * eb + k) * 8 +: 8] = b[(2 * e * eb + k) * 8 +: 8];
                        nb[(2 * e * eb + k) * 8 +: 8] = a[((2 * e + 1) * eb + k) * 8 +: 8];
                    end
                end
            end
        end
        // With both operands the same register, both halves carry the swapped value.
        if (same) begin
            nb = na;
        end
        return {nb, na};
    endfunction

    function automatic logic [127:0] trn_pair(input logic [63:0] a, input logic [63:0] b,
                                              input logic same, input logic [1:0] sc);
        logic [127:0] r;
        unique case (sc)
            SIZE_8:  r = trn_core(a, b, same, EB_8);
            SIZE_16: r = trn_core(a, b, same, EB_16);
            default: r = trn_core(a, b, same, EB_32);
        endcase
        return r;
    endfunction

    // Unzip or zip over a concatenation whose halves are hb bytes each.
    function automatic logic [255:0] uz_core(input logic [255:0] cat, input logic zip,
                                             input int hb, input int eb);
        logic [255:0] res;
        int           src;
        int           dst;
        res = '0;
        for (int e = 0; e < 32; e++) begin
            for (int k = 0; k < 4; k++) begin
                if ((k < eb) && (e * eb < 2 * hb)) begin
                    if (zip) begin
                        src = (e & 1) * hb + (e >> 1) * eb + k;
                        dst = e * eb + k;
                    end
                    else begin
                        src = e * eb + k;
                        dst = (e & 1) * hb + (e >> 1) * eb + k;
                    end
                    res[dst * 8 +: 8] = cat[src * 8 +: 8];
                end
            end
        end
        return res;
    endfunction

    function automatic logic [255:0] uz_pair(input logic [255:0] cat, input logic zip,
                                             input logic quad, input logic [1:0] sc);
        logic [255:0] r;
        if (quad) begin
            unique case (sc)
                SIZE_8:  r = uz_core(cat, zip, 16, EB_8);
                SIZE_16: r = uz_core(cat, zip, 16, EB_16);
                default: r = uz_core(cat, zip, 16, EB_32);
            endcase
        end
        else begin
            unique case (sc)
                SIZE_8:  r = uz_core(cat, zip, 8, EB_8);
                SIZE_16: r = uz_core(cat, zip, 8, EB_16);
                default: r = uz_core(cat, zip, 8, EB_32);
            endcase
        end
        return r;
    endfunction

endpackage

// ----- src/simd_transpose_unzip_zip_unit.sv -----
// Vector permute unit: register file with write, read, transpose, unzip and zip.
// Each transaction passes through the input register and then the result register,
// from which its result is offered.
// Throughput: one transaction per cycle unless the result is stalled; the register file update
// and the result are both produced by one pass of mux logic between the input and result registers.
// Reset (rst_n, asynchronous, active low) clears every vector register to zero and
// empties both pipeline registers.
module simd_transpose_unzip_zip_unit
    import stuz_pkg::*;
#(
    parameter int REG_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [1:0]  size_code,
    input  logic        quad,
    input  logic [4:0]  d_index,
    input  logic [4:0]  m_index,
    input  logic [63:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] read_data,
    output logic        error
);

    localparam int XW = IDX_EXT_W;

    // The input register holds one transaction until the result register can take it.
    logic              in_valid_reg;
    logic [2:0]        opcode_reg;
    logic [1:0]        size_reg;
    logic              quad_reg;
    logic [4:0]        d_reg;
    logic [4:0]        m_reg;
    logic [63:0]       wdata_reg;

    logic              out_valid_reg;
    logic [63:0]       read_data_reg;
    logic              error_reg;
    logic [63:0]       read_data_next;
    logic              error_next;

    logic [63:0]       vregs_reg  [REG_COUNT];
    logic [63:0]       vregs_next [REG_COUNT];

    logic              advance;
    logic [XW-1:0]     d0;
    logic [XW-1:0]     d1;
    logic [XW-1:0]     m0;
    logic [XW-1:0]     m1;
    logic              d_ok;
    logic              perm_err;
    logic [63:0]       rd_d0;
    logic [63:0]       rd_d1;
    logic [63:0]       rd_m0;
    logic [63:0]       rd_m1;
    logic [127:0]      t0;
    logic [127:0]      t1;
    logic [63:0]       a1;
    logic [63:0]       b1;
    logic [255:0]      cat;
    logic [255:0]      uz_res;
    logic [63:0]       u_m0;

    // The stage moves on whenever the result register is empty or being emptied.
    // A stalled result keeps the next transaction waiting in the input register,
    // and a further transaction is refused until the result leaves.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg <= opcode;
            size_reg   <= size_code;
            quad_reg   <= quad;
            d_reg      <= d_index;
            m_reg      <= m_index;
            wdata_reg  <= write_data;
        end
    end

    // Operand indices, widened so that the second register of a pair and the
    // register count can be compared without wrapping.
    always_comb
    begin
        d0       = XW'(d_reg);
        m0       = XW'(m_reg);
        d1       = d0 + XW'(1);
        m1       = m0 + XW'(1);
        d_ok     = d0 < XW'(REG_COUNT);
        perm_err = (size_reg == SIZE_RSVD)
                || ((quad_reg ? d1 : d0) >= XW'(REG_COUNT))
                || ((quad_reg ? m1 : m0) >= XW'(REG_COUNT));
    end

    // Register file read ports; an index beyond the file reads as zero.
    always_comb
    begin
        rd_d0 = '0;
        rd_d1 = '0;
        rd_m0 = '0;
        rd_m1 = '0;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            if (d0 == XW'(i)) rd_d0 = vregs_reg[i];
            if (d1 == XW'(i)) rd_d1 = vregs_reg[i];
            if (m0 == XW'(i)) rd_m0 = vregs_reg[i];
            if (m1 == XW'(i)) rd_m1 = vregs_reg[i];
        end
    end

    // Transpose runs register by register. The second pair must see what the
    // first pair left behind when the two pairs overlap, so its operands are
    // forwarded from the first step's results.
    always_comb
    begin
        t0 = trn_pair(rd_d0, rd_m0, d0 == m0, size_reg);
        a1 = (d1 == m0) ? t0[127:64] : rd_d1;
        b1 = (m1 == d0) ? t0[63:0]   : rd_m1;
        t1 = trn_pair(a1, b1, d1 == m1, size_reg);
    end

    // Unzip and zip read both sides in full before anything is written.
    always_comb
    begin
        cat    = quad_reg ? {rd_m1, rd_m0, rd_d1, rd_d0} : {128'b0, rd_m0, rd_d0};
        uz_res = uz_pair(cat, opcode_reg == OP_ZIP, quad_reg, size_reg);
        u_m0   = quad_reg ? uz_res[191:128] : uz_res[127:64];
    end

    // Register file update. Where operands overlap, the later write wins:
    // transpose writes d, m, d+1, m+1 in that order, unzip and zip write the
    // whole d side before the whole m side.
    always_comb
    begin
        vregs_next = vregs_reg;
        if (advance)
        begin
            unique case (opcode_t'(opcode_reg))
                OP_WRITE:
                begin
                    for (int i = 0; i < REG_COUNT; i++)
                    begin
                        if (d_ok && (d0 == XW'(i))) vregs_next[i] = wdata_reg;
                    end
                end
                OP_TRN:
                begin
                    for (int i = 0; i < REG_COUNT; i++)
                    begin
                        if (!perm_err)
                        begin
                            priority if (quad_reg && (m1 == XW'(i))) vregs_next[i] = t1[127:64];
                            else if (quad_reg && (d1 == XW'(i)))     vregs_next[i] = t1[63:0];
                            else if (m0 == XW'(i))                   vregs_next[i] = t0[127:64];
                            else if (d0 == XW'(i))                   vregs_next[i] = t0[63:0];
                            else                                     vregs_next[i] = vregs_reg[i];
                        end
                    end
                end
                OP_UZP, OP_ZIP:
                begin
                    for (int i = 0; i < REG_COUNT; i++)
                    begin
                        if (!perm_err)
                        begin
                            priority if (quad_reg && (m1 == XW'(i))) vregs_next[i] = uz_res[255:192];
                            else if (m0 == XW'(i))                   vregs_next[i] = u_m0;
                            else if (quad_reg && (d1 == XW'(i)))     vregs_next[i] = uz_res[127:64];
                            else if (d0 == XW'(i))                   vregs_next[i] = uz_res[63:0];
                            else                                     vregs_next[i] = vregs_reg[i];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                vregs_reg[i] <= '0;
            end
        end
        else
        begin
            vregs_reg <= vregs_next;
        end
    end

    // Result of the transaction in the input register. Unknown opcodes
    // return zero with no error.
    always_comb
    begin
        read_data_next = '0;
        error_next     = 1'b0;
        unique case (opcode_t'(opcode_reg))
            OP_WRITE:
            begin
                error_next = !d_ok;
            end
            OP_READ:
            begin
                error_next     = !d_ok;
                read_data_next = d_ok ? rd_d0 : '0;
            end
            OP_TRN, OP_UZP, OP_ZIP:
            begin
                error_next = perm_err;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg <= read_data_next;
            error_reg     <= error_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign error     = error_reg;

endmodule

// ----- src/stuz_checker.sv -----
// Port-level checker for the vector permute unit, with its bind statement.
module stuz_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] read_data,
    input logic        error
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(error))
        else $error("result changed while stalled");

    // A refused operation never returns data.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> read_data == 64'd0)
        else $error("error result carries data");

    // The input side only stalls behind a result that is itself stalled.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // An accepted transaction into an empty unit is offered once it has passed the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("result not offered after two cycles");

endmodule

bind simd_transpose_unzip_zip_unit stuz_checker u_stuz_checker (.*);
